@@ design/elc_pkg.sv @@
package elc_pkg;
    localparam int MaxFloorsDef = 16;
    localparam int TimeWidthDef = 32;
    localparam int TotW = 32;
    localparam logic [1:0] CfgFloors = 2'd0;
    localparam logic [1:0] CfgCap    = 2'd1;
    localparam logic [1:0] CfgTravel = 2'd2;
    localparam logic [1:0] CfgStop   = 2'd3;
    localparam logic ActCall = 1'b0;
    localparam logic ActStep = 1'b1;
endpackage

@@ design/elevator_look_controller_unit.sv @@
// channel | signals                              | direction
// config  | i_cfg_we, i_cfg_idx, i_cfg_data      | in, write only
// item    | i_valid/o_ready + action/call fields | in
// result  | o_valid/i_ready + result fields      | out
// a call item: read slot, decide, write, then present the result.
// a floor visit goes through the slot memory port: one drop-off sweep over all
// slots, then one pickup read-modify-write.
// after reset the slot memory is cleared while no item is taken. a stalled result
// holds the block; the next item is taken once the result is transferred.
module elevator_look_controller_unit #(
    parameter int MAX_FLOORS = elc_pkg::MaxFloorsDef,
    parameter int TIME_WIDTH = elc_pkg::TimeWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [4:0]  i_call_floor,
    input  logic [4:0]  i_call_destination,
    input  logic [2:0]  i_call_passengers,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_call_accepted,
    output logic [4:0]  o_car_floor,
    output logic        o_going_up,
    output logic [5:0]  o_car_load,
    output logic [5:0]  o_dropped_count,
    output logic [2:0]  o_picked_count,
    output logic [31:0] o_now_time,
    output logic [31:0] o_served_total,
    output logic [31:0] o_wait_total,
    output logic [31:0] o_turnaround_total,
    output logic [31:0] o_calls_done
);
    import elc_pkg::*;

    localparam int Slots = 2 * MAX_FLOORS;
    localparam int SW = $clog2(Slots);
    localparam int FW = $clog2(MAX_FLOORS + 1);
    localparam int TW = TIME_WIDTH;
    localparam int EW = 5 + 3 + 1 + 2 * TW;   // dest, pass, picked, call t, pickup t
    localparam logic [TW-1:0] TMax = '1;
    localparam logic [TotW-1:0] TotMax = '1;

    // states
    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_CRD = 4'd2, S_CWR = 4'd3,
                           S_DSW = 4'd4, S_DLAST = 4'd5, S_REV = 4'd6, S_PRD = 4'd7,
                           S_PWT = 4'd8, S_PWR = 4'd9, S_TIM = 4'd10, S_OUT = 4'd11,
                           S_TR = 4'd12;

    // slot memory: one entry per slot
    logic [EW-1:0] mem [Slots];
    logic [EW-1:0] r_rd;
    logic          r_we;
    logic          n_we;
    logic [SW-1:0] r_wa, r_ra;
    logic [EW-1:0] r_wd;

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        r_rd <= mem[r_ra];
    end

    logic [4:0] rd_dest;
    logic [2:0] rd_pass;
    logic       rd_pick;
    logic [TW-1:0] rd_ct, rd_pt;
    assign {rd_dest, rd_pass, rd_pick, rd_ct, rd_pt} = r_rd;

    // config
    logic [4:0] r_nf_cfg;
    logic [5:0] r_cap;
    logic [7:0] r_travel, r_stop;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf_cfg <= 5'd16; r_cap <= 6'd10; r_travel <= 8'd1; r_stop <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgFloors: r_nf_cfg <= i_cfg_data[4:0];
                CfgCap:    r_cap    <= i_cfg_data[5:0];
                CfgTravel: r_travel <= i_cfg_data;
                CfgStop:   r_stop   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [FW-1:0] nf;
    always_comb begin
        if (r_nf_cfg < 5'd2) nf = FW'(2);
        else if (32'(r_nf_cfg) > MAX_FLOORS) nf = FW'(MAX_FLOORS);
        else nf = FW'(r_nf_cfg);
    end

    // control and state
    logic [3:0]  r_st;
    logic [SW:0] r_cnt;
    logic [FW-1:0] r_pos;
    logic        r_up;
    logic [5:0]  r_load;
    logic [TW-1:0] r_clk;
    logic [TotW-1:0] r_served, r_wait, r_turn, r_done;
    logic [MAX_FLOORS-1:0] r_pend;   // floor has a live slot, built during sweep
    logic        r_act;
    logic [4:0]  r_cf, r_cd;
    logic [2:0]  r_cp;
    logic        r_acc, r_stopped;
    logic [5:0]  r_drop;
    logic [2:0]  r_pick;
    logic [FW-1:0] r_here;
    logic [SW-1:0] r_iss;   // slot whose read was issued last cycle
    logic [SW-1:0] r_cur;   // slot whose data is in r_rd during sweep

    function automatic logic [TotW-1:0] sat32(input logic [TotW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TotW+TW:0] s;
        s = (TotW+TW+1)'(a) + (TotW+TW+1)'(b);
        return (s > (TotW+TW+1)'(TotMax)) ? TotMax : s[TotW-1:0];
    endfunction

    function automatic logic [TW-1:0] satt(input logic [TW-1:0] a, input logic [7:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + (TW+1)'(b);
        return s[TW] ? TMax : s[TW-1:0];
    endfunction

    // call validity and slot
    logic call_ok;
    logic [SW-1:0] call_slot;
    always_comb begin
        call_ok = (r_cf >= 5'd1) && (FW'(r_cf) <= nf) && (r_cf[4] == 1'b0 || FW > 4 ||
                  1'b1) && (r_cd >= 5'd1) && (FW'(r_cd) <= nf) && (r_cd != r_cf)
                  && (r_cp != 3'd0) && (32'(r_cf) <= MAX_FLOORS) && (32'(r_cd) <= MAX_FLOORS);
        call_slot = SW'((32'(r_cf) - 32'd1) * 2 + ((r_cd > r_cf) ? 32'd1 : 32'd0));
    end

    // extremes from pending bits, floor f at bit f-1
    logic [FW-1:0] lowf, highf;
    always_comb begin
        lowf = '0; highf = '0;
        for (int f = MAX_FLOORS; f >= 1; f--)
            if (r_pend[f-1] && FW'(f) <= nf) lowf = FW'(f);
        for (int f = 1; f <= MAX_FLOORS; f++)
            if (r_pend[f-1] && FW'(f) <= nf) highf = FW'(f);
    end

    logic [SW-1:0] pick_slot;
    assign pick_slot = SW'((32'(r_here) - 32'd1) * 2 + 32'(r_up));

    logic drop_hit;
    assign drop_hit = (FW'(rd_dest) == r_here) && (rd_dest != 5'd0) && rd_pick &&
                      (r_cur[0] == r_up) && (32'(rd_dest) <= MAX_FLOORS);
    logic [6:0] pick_sum;
    assign pick_sum = {1'b0, r_load} + 7'(rd_pass);
    logic pick_ok;
    assign pick_ok = (rd_dest != 5'd0) && !rd_pick && (pick_sum <= 7'(r_cap));
    // read data of the sweep is valid once the read has passed r_ra and r_rd
    logic sweep_live;
    assign sweep_live = (r_cnt >= (SW+1)'(2));

    // memory write strobe for the next cycle
    always_comb begin
        n_we = (r_st == S_CLR) ||
               (r_st == S_CWR && call_ok && rd_dest == 5'd0) ||
               ((r_st == S_DSW || r_st == S_DLAST) && sweep_live && drop_hit) ||
               (r_st == S_PWR && pick_ok);
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_TR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
            r_st <= S_CLR; r_cnt <= '0; r_pos <= FW'(1); r_up <= 1'b1; r_load <= '0;
            r_clk <= '0; r_served <= '0; r_wait <= '0; r_turn <= '0; r_done <= '0;
        end else begin
            r_we <= n_we;
            unique case (r_st)
                S_CLR: begin
                    r_wa <= r_cnt[SW-1:0]; r_wd <= '0;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (SW+1)'(Slots - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_act <= i_action; r_cf <= i_call_floor; r_cd <= i_call_destination;
                    r_cp <= i_call_passengers; r_acc <= 1'b0; r_drop <= '0; r_pick <= '0;
                    r_stopped <= 1'b0; r_pend <= '0; r_cnt <= '0;
                    if (i_action == ActCall) r_st <= S_CRD;
                    else begin
                        // clamp car
                        if (r_pos < FW'(1)) r_here <= FW'(1);
                        else if (r_pos > nf) r_here <= nf;
                        else r_here <= r_pos;
                        r_st <= S_DSW;
                    end
                end
                S_CRD: begin r_ra <= call_slot; r_st <= S_PWT; r_cnt <= '1; end
                S_CWR: begin
                    if (call_ok && rd_dest == 5'd0) begin
                        r_wa <= call_slot;
                        r_wd <= {r_cd, r_cp, 1'b0, r_clk, {TW{1'b0}}};
                        r_acc <= 1'b1;
                    end
                    r_st <= S_OUT;
                end
                S_DSW, S_DLAST: begin
                    // issue read of r_cnt, process data of slot r_cur, whose read went through r_ra and r_rd
                    if (r_cnt <= (SW+1)'(Slots - 1)) r_ra <= r_cnt[SW-1:0];
                    if (sweep_live) begin
                        if (drop_hit) begin
                            r_drop <= r_drop + 6'(rd_pass);
                            r_served <= sat32(r_served, TW'(rd_pass));
                            r_wait <= sat32(r_wait, rd_pt - rd_ct);
                            r_turn <= sat32(r_turn, r_clk - rd_ct);
                            r_done <= sat32(r_done, TW'(1));
                            r_wa <= r_cur; r_wd <= '0;
                        end else if (rd_dest != 5'd0) begin
                            r_pend[r_cur[SW-1:1]] <= 1'b1;
                        end
                    end
                    r_iss <= r_cnt[SW-1:0];
                    r_cur <= r_iss;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (SW+1)'(Slots + 1)) r_st <= S_REV;
                end
                S_REV: begin
                    if (r_drop != '0) begin
                        r_stopped <= 1'b1;
                        r_load <= (r_drop > r_load) ? 6'd0 : r_load - r_drop;
                    end
                    if (r_up) begin
                        if (r_here == highf || r_here == nf) r_up <= 1'b0;
                    end else begin
                        if (r_here == lowf || r_here == FW'(1)) r_up <= 1'b1;
                    end
                    r_pos <= r_here;
                    r_st <= S_PRD;
                end
                S_PRD: begin r_ra <= pick_slot; r_cnt <= '0; r_st <= S_PWT; end
                S_PWT: r_st <= (r_cnt == '1) ? S_CWR : S_PWR;
                S_PWR: begin
                    if (pick_ok) begin
                        r_wa <= pick_slot;
                        r_wd <= {rd_dest, rd_pass, 1'b1, rd_ct, r_clk};
                        r_pick <= rd_pass;
                        r_load <= pick_sum[5:0];
                        r_stopped <= 1'b1;
                    end
                    r_st <= S_TIM;
                end
                S_TIM: begin
                    r_clk <= satt(r_stopped ? satt(r_clk, r_stop) : r_clk, r_travel);
                    if (r_up) begin
                        if (r_pos < nf) r_pos <= r_pos + 1'b1;
                    end else if (r_pos > FW'(1)) r_pos <= r_pos - 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: r_st <= S_TR;
                S_TR: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_call_accepted   = r_acc;
    assign o_car_floor       = 5'(r_pos);
    assign o_going_up        = r_up;
    assign o_car_load        = r_load;
    assign o_dropped_count   = r_drop;
    assign o_picked_count    = r_pick;
    assign o_now_time        = 32'(r_clk);
    assign o_served_total    = r_served;
    assign o_wait_total      = r_wait;
    assign o_turnaround_total = r_turn;
    assign o_calls_done      = r_done;
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import elc_pkg::*;

    localparam int NSLOT = 2 * MaxFloorsDef;
    localparam logic [31:0] SAT = 32'hFFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [4:0]  i_call_floor;
    logic [4:0]  i_call_destination;
    logic [2:0]  i_call_passengers;
    logic        o_valid;
    logic        i_ready;
    logic        o_call_accepted;
    logic [4:0]  o_car_floor;
    logic        o_going_up;
    logic [5:0]  o_car_load;
    logic [5:0]  o_dropped_count;
    logic [2:0]  o_picked_count;
    logic [31:0] o_now_time;
    logic [31:0] o_served_total;
    logic [31:0] o_wait_total;
    logic [31:0] o_turnaround_total;
    logic [31:0] o_calls_done;

    elevator_look_controller_unit u_dut (.*);

    typedef struct packed {
        logic       action;
        logic [4:0] flr;
        logic [4:0] dest;
        logic [2:0] pass;
    } request_t;

    typedef struct packed {
        logic        accepted;
        logic [4:0]  car_floor;
        logic        going_up;
        logic [5:0]  load;
        logic [5:0]  dropped;
        logic [2:0]  picked;
        logic [31:0] now;
        logic [31:0] served;
        logic [31:0] waited;
        logic [31:0] turnaround;
        logic [31:0] calls;
    } car_report_t;

    // shadow of the controller state
    logic [4:0]  sh_dest   [NSLOT];
    logic [2:0]  sh_pass   [NSLOT];
    logic        sh_picked [NSLOT];
    logic [31:0] sh_called [NSLOT];
    logic [31:0] sh_boarded[NSLOT];
    logic [4:0]  sh_pos;
    logic        sh_up;
    logic [5:0]  sh_load;
    logic [31:0] sh_clock;
    logic [31:0] sh_served, sh_waited, sh_turn, sh_calls;
    logic [4:0]  r_floors;
    logic [5:0]  r_cap;
    logic [7:0]  r_travel, r_stop;

    request_t    pending_requests[$];
    car_report_t expected_reports[$];
    int          n_errors = 0;
    bit          stim_done = 0;
    bit          quiet = 0;          // no idling in the last part
    int          hold_off = 0;       // long receiver stall, in cycles

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT : s[31:0];
    endfunction

    function automatic int slot_index(int flr, bit up);
        return ((flr - 1) * 2 + (up ? 1 : 0)) % NSLOT;
    endfunction

    task automatic shadow_reset();
        for (int s = 0; s < NSLOT; s++) begin
            sh_dest[s] = 0; sh_pass[s] = 0; sh_picked[s] = 0;
            sh_called[s] = 0; sh_boarded[s] = 0;
        end
        sh_pos = 1; sh_up = 1; sh_load = 0; sh_clock = 0;
        sh_served = 0; sh_waited = 0; sh_turn = 0; sh_calls = 0;
        r_floors = 16; r_cap = 10; r_travel = 1; r_stop = 2;
    endtask

    // one item through the controller, result pushed on the expected queue
    task automatic predict_visit(request_t rq);
        int nf, here, low, high, s, dropped, picked;
        bit stopped;
        car_report_t rp;
        nf = (r_floors < 2) ? 2 : (r_floors > MaxFloorsDef ? MaxFloorsDef : r_floors);
        dropped = 0; picked = 0; stopped = 0; low = 0; high = 0;
        rp = '0;
        if (rq.action == ActCall) begin
            if (rq.flr >= 1 && rq.flr <= nf && rq.dest >= 1 && rq.dest <= nf &&
                rq.dest != rq.flr && rq.pass != 0) begin
                s = slot_index(rq.flr, rq.dest > rq.flr);
                if (sh_dest[s] == 0) begin
                    sh_dest[s] = rq.dest; sh_pass[s] = rq.pass; sh_picked[s] = 0;
                    sh_called[s] = sh_clock; sh_boarded[s] = 0;
                    rp.accepted = 1;
                end
            end
        end else begin
            if (sh_pos < 1) sh_pos = 1;
            if (sh_pos > nf) sh_pos = 5'(nf);
            here = sh_pos;
            // riders of the current direction get off here
            for (s = 0; s < NSLOT; s++) begin
                if (sh_dest[s] == here && sh_picked[s] && s[0] == sh_up) begin
                    dropped += sh_pass[s];
                    sh_served = sat_add(sh_served, 32'(sh_pass[s]));
                    sh_waited = sat_add(sh_waited, sh_boarded[s] - sh_called[s]);
                    sh_turn   = sat_add(sh_turn, sh_clock - sh_called[s]);
                    sh_calls  = sat_add(sh_calls, 32'd1);
                    sh_dest[s] = 0; sh_pass[s] = 0; sh_picked[s] = 0;
                    sh_called[s] = 0; sh_boarded[s] = 0;
                end
            end
            if (dropped != 0) begin
                stopped = 1;
                sh_load = (dropped > sh_load) ? 6'd0 : 6'(sh_load - dropped);
            end
            for (int f = 1; f <= nf; f++) begin
                if (sh_dest[slot_index(f, 0)] != 0 || sh_dest[slot_index(f, 1)] != 0) begin
                    if (low == 0) low = f;
                    high = f;
                end
            end
            if (sh_up) begin
                if (here == high || here == nf) sh_up = 0;
            end else begin
                if (here == low || here == 1) sh_up = 1;
            end
            s = slot_index(here, sh_up);
            if (sh_dest[s] != 0 && !sh_picked[s] && int'(sh_load) + sh_pass[s] <= r_cap) begin
                sh_picked[s] = 1;
                sh_boarded[s] = sh_clock;
                picked = sh_pass[s];
                sh_load = 6'(sh_load + picked);
                stopped = 1;
            end
            if (stopped) sh_clock = sat_add(sh_clock, 32'(r_stop));
            sh_clock = sat_add(sh_clock, 32'(r_travel));
            if (sh_up) begin
                if (sh_pos < nf) sh_pos++;
            end else begin
                if (sh_pos > 1) sh_pos--;
            end
            if (sh_pos > nf) sh_pos = 5'(nf);
        end
        rp.car_floor = sh_pos; rp.going_up = sh_up; rp.load = sh_load;
        rp.dropped = 6'(dropped); rp.picked = 3'(picked); rp.now = sh_clock;
        rp.served = sh_served; rp.waited = sh_waited;
        rp.turnaround = sh_turn; rp.calls = sh_calls;
        expected_reports.push_back(rp);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // clock and limit
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #200_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // driver: takes the next pending item, idles in bursts
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_visit({i_action, i_call_floor, i_call_destination,
                               i_call_passengers});
            end
            if (!i_valid || o_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    request_t rq;
                    rq = pending_requests.pop_front();
                    i_valid <= 1'b1;
                    {i_action, i_call_floor, i_call_destination, i_call_passengers} <= rq;
                    if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each transfer, stalls in bursts or in a long hold-off
    int dst_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    car_report_t w;
                    w = expected_reports.pop_front();
                    if (o_call_accepted !== w.accepted)
                        report_mismatch("call_accepted", o_call_accepted, w.accepted);
                    if (o_car_floor !== w.car_floor)
                        report_mismatch("car_floor", o_car_floor, w.car_floor);
                    if (o_going_up !== w.going_up)
                        report_mismatch("going_up", o_going_up, w.going_up);
                    if (o_car_load !== w.load) report_mismatch("car_load", o_car_load, w.load);
                    if (o_dropped_count !== w.dropped)
                        report_mismatch("dropped_count", o_dropped_count, w.dropped);
                    if (o_picked_count !== w.picked)
                        report_mismatch("picked_count", o_picked_count, w.picked);
                    if (o_now_time !== w.now) report_mismatch("now_time", o_now_time, w.now);
                    if (o_served_total !== w.served)
                        report_mismatch("served_total", o_served_total, w.served);
                    if (o_wait_total !== w.waited)
                        report_mismatch("wait_total", o_wait_total, w.waited);
                    if (o_turnaround_total !== w.turnaround)
                        report_mismatch("turnaround_total", o_turnaround_total, w.turnaround);
                    if (o_calls_done !== w.calls)
                        report_mismatch("calls_done", o_calls_done, w.calls);
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 1'b0;
            end else if (dst_gap > 0) begin
                dst_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) dst_gap = $urandom_range(1, 17);
            end
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgFloors: r_floors = val[4:0];
            CfgCap:    r_cap = val[5:0];
            CfgTravel: r_travel = val;
            default:   r_stop = val;
        endcase
    endtask

    // wait until the block has drained, then a settling pause
    task automatic drain();
        while (pending_requests.size() > 0 || expected_reports.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic request_t call_req(int f, int d, int p);
        return '{action: ActCall, flr: 5'(f), dest: 5'(d), pass: 3'(p)};
    endfunction

    function automatic request_t step_req();
        return '{action: ActStep, flr: 5'($urandom), dest: 5'($urandom),
                 pass: 3'($urandom)};
    endfunction

    // mostly valid calls in the served range, some noise, many visits
    task automatic random_phase(int n, int nf);
        for (int k = 0; k < n; k++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                pending_requests.push_back(step_req());
            end else if (sel < 90) begin
                pending_requests.push_back(call_req($urandom_range(1, nf),
                    $urandom_range(1, nf), $urandom_range(1, 7)));
            end else begin
                pending_requests.push_back(call_req($urandom, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        i_clk = 1'b0; i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_ready = 1'b0;
        i_action = 1'b0; i_call_floor = '0; i_call_destination = '0;
        i_call_passengers = '0;
        shadow_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, bad calls, occupied slot, building ends
        pending_requests.push_back(call_req(1, 16, 7));
        pending_requests.push_back(call_req(1, 16, 3));   // occupied slot
        pending_requests.push_back(call_req(16, 1, 7));
        pending_requests.push_back(call_req(0, 5, 1));    // floor out of range
        pending_requests.push_back(call_req(5, 17, 1));   // destination out of range
        pending_requests.push_back(call_req(31, 31, 7));
        pending_requests.push_back(call_req(4, 4, 2));    // destination equals floor
        pending_requests.push_back(call_req(3, 8, 0));    // zero passengers
        pending_requests.push_back(call_req(8, 2, 5));
        for (int k = 0; k < 16; k++) pending_requests.push_back(step_req());
        drain();

        // long receiver hold-off while calls keep coming
        hold_off = 400;
        random_phase(40, 16);
        drain();

        // small building, tight capacity, extreme timing
        cfg_write(CfgFloors, 8'd2);
        cfg_write(CfgCap, 8'd1);
        cfg_write(CfgTravel, 8'd255);
        cfg_write(CfgStop, 8'd0);
        random_phase(250, 2);
        drain();

        // out-of-range floor count, zero capacity
        cfg_write(CfgFloors, 8'd31);
        cfg_write(CfgCap, 8'd0);
        cfg_write(CfgTravel, 8'd0);
        cfg_write(CfgStop, 8'd255);
        random_phase(150, 16);
        drain();

        cfg_write(CfgFloors, 8'd0);
        cfg_write(CfgCap, 8'd63);
        cfg_write(CfgTravel, 8'd255);
        cfg_write(CfgStop, 8'd255);
        random_phase(150, 2);
        drain();

        cfg_write(CfgFloors, 8'd16);
        cfg_write(CfgCap, 8'd10);
        cfg_write(CfgTravel, 8'($urandom_range(0, 255)));
        cfg_write(CfgStop, 8'($urandom_range(0, 255)));
        random_phase(350, 16);
        drain();

        cfg_write(CfgFloors, 8'd7);
        cfg_write(CfgCap, 8'($urandom_range(1, 63)));
        quiet = 1;
        random_phase(250, 7);
        drain();

        stim_done = 1;
        if (n_errors == 0 && expected_reports.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

@@ elevator_look_controller_unit.f @@
design/elc_pkg.sv
design/elevator_look_controller_unit.sv
bench/testbench.sv
